@@ rtl/sample_window_chunk_framer_top_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the sample window chunk framer
// Shared property wrappers on clk_i, with and without the reset disable.
// ----------------------------------------------------------------------------
`ifndef SAMPLE_WINDOW_CHUNK_FRAMER_TOP_MACROS_SVH
`define SAMPLE_WINDOW_CHUNK_FRAMER_TOP_MACROS_SVH

// Check a property on every clock edge outside reset.
`define SWCF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define SWCF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ rtl/swcf_pkg.sv @@
// ----------------------------------------------------------------------------
// swcf_pkg
// Types and constants shared by the sample window chunk framer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package swcf_pkg;

  localparam int CHUNK_SAMPLES = 32;
  localparam int HEADER_BYTES  = 8;
  localparam int SAMPLE_BYTES  = 6;
  localparam int FRAME_BYTES   = HEADER_BYTES + SAMPLE_BYTES;
  localparam int IDX_W         = $clog2(FRAME_BYTES);
  localparam int WIN_W         = 13;
  localparam int CHUNK_W       = $clog2(CHUNK_SAMPLES + 1);
  localparam int SEQ_W         = 32;
  localparam int CIDX_W        = 8;

  localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(256);

  typedef struct packed {
    logic signed [31:0] accel_x;
    logic signed [31:0] accel_y;
    logic signed [31:0] accel_z;
  } in_word_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_of_frame;
    logic       last_of_window;
  } out_word_t;

  // One accepted sample with its frame header context.
  typedef struct packed {
    in_word_t          sample;
    logic [SEQ_W-1:0]  seq;
    logic [CIDX_W-1:0] chunk_idx;
    logic [CIDX_W-1:0] total;
    logic [15:0]       cnt;
    logic              hdr;
    logic              last_frame;
    logic              last_win;
  } item_t;

endpackage

@@ rtl/sample_window_chunk_framer_top.sv @@
// ----------------------------------------------------------------------------
// sample_window_chunk_framer_top
// Scales accelerometer samples to milli-g and frames them into byte chunks.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | word
//  --------+-----------+------------------------+------------------------------
//  in      | input     | in_valid_i / in_stall_o  | in_word_t (accel x, y, z)
//  out     | output    | out_valid_o / out_stall_i| out_word_t (byte and marks)
//  cfg     | input     | cfg_valid_i / cfg_ready_o| window_samples, 13 bits
//
//  Each sample leaves as 6 bytes, or 14 when it opens a chunk; the byte-wide
//  output register sets the rate, one byte per cycle while out_stall_i is low.
//  Three stages: sample register, frame register, output register.
//  rst_ni clears all control state asynchronously; window length resets to 256.
//  A stall on the output holds the byte register and backs up through the
//  frame and sample registers into in_stall_o.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sample_window_chunk_framer_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  swcf_pkg::in_word_t          in_word_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output swcf_pkg::out_word_t         out_word_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [swcf_pkg::WIN_W-1:0]  cfg_data_i
);

  localparam logic [swcf_pkg::IDX_W-1:0] LAST_IDX =
    swcf_pkg::IDX_W'(swcf_pkg::FRAME_BYTES - 1);
  localparam logic [swcf_pkg::IDX_W-1:0] PAYLOAD_IDX =
    swcf_pkg::IDX_W'(swcf_pkg::HEADER_BYTES);

  // Window position state and the length register.
  logic [swcf_pkg::WIN_W-1:0]   win_q;
  logic [swcf_pkg::SEQ_W-1:0]   seq_q,  seq_d;
  logic [swcf_pkg::WIN_W-1:0]   siw_q,  siw_d;
  logic [swcf_pkg::CIDX_W-1:0]  cn_q,   cn_d;
  logic [swcf_pkg::CHUNK_W-1:0] sic_q,  sic_d;

  // Pipeline registers.
  logic                 item_valid_q;
  swcf_pkg::item_t      item_q, item_d;
  logic                 frame_valid_q;
  logic [swcf_pkg::FRAME_BYTES-1:0][7:0] frame_q, frame_d;
  logic                 frame_lf_q, frame_lw_q;
  logic [swcf_pkg::IDX_W-1:0] idx_q;
  logic                 out_valid_q;
  swcf_pkg::out_word_t  out_q;

  logic in_take, keep, adv, frame_done, frame_load;
  logic [15:0] milli_x, milli_y, milli_z;

  // --------------------------------------------------------------------------
  // Handshake. The output register moves when empty or not stalled; the
  // frame register frees up as its last byte moves; the sample register
  // frees up as it loads the frame register.
  // --------------------------------------------------------------------------
  assign adv        = frame_valid_q && (!out_valid_q || !out_stall_i);
  assign frame_done = adv && (idx_q == LAST_IDX);
  assign frame_load = item_valid_q && (!frame_valid_q || frame_done);
  assign in_stall_o = item_valid_q && !frame_load;
  assign in_take    = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  // --------------------------------------------------------------------------
  // Window bookkeeping at accept: decide header, counts and end marks.
  // --------------------------------------------------------------------------
  logic                         wrap, n_zero, win_start, last_win, last_frame;
  logic [swcf_pkg::WIN_W-1:0]   siw, remaining, cnt;
  logic [swcf_pkg::CIDX_W-1:0]  cn;
  logic [swcf_pkg::CHUNK_W-1:0] sic;
  logic [swcf_pkg::WIN_W:0]     total_w;

  always_comb begin
    n_zero    = (win_q == '0);
    // Drop a stale position past the window end: open a new window.
    wrap      = (siw_q >= win_q);
    siw       = wrap ? '0 : siw_q;
    cn        = wrap ? '0 : cn_q;
    sic       = wrap ? '0 : sic_q;
    remaining = win_q - siw;
    cnt       = (remaining < swcf_pkg::WIN_W'(swcf_pkg::CHUNK_SAMPLES)) ?
                remaining : swcf_pkg::WIN_W'(swcf_pkg::CHUNK_SAMPLES);
    total_w   = (swcf_pkg::WIN_W+1)'(
                  ({1'b0, win_q} + (swcf_pkg::WIN_W+1)'(swcf_pkg::CHUNK_SAMPLES - 1))
                  / swcf_pkg::CHUNK_SAMPLES);
    win_start = (sic == '0) && (siw == '0);
    last_win  = ({1'b0, siw} + 1'b1) >= {1'b0, win_q};
    last_frame = last_win ||
                 (({1'b0, sic} + 1'b1) >= (swcf_pkg::CHUNK_W+1)'(swcf_pkg::CHUNK_SAMPLES));

    seq_d = win_start ? (seq_q + 1'b1) : seq_q;
    if (win_start) begin
      cn = '0;
    end

    if (last_win) begin
      siw_d = '0;
      cn_d  = '0;
      sic_d = '0;
    end else begin
      siw_d = siw + 1'b1;
      cn_d  = last_frame ? (cn + 1'b1) : cn;
      sic_d = last_frame ? '0 : (sic + 1'b1);
    end

    item_d.sample     = in_word_i;
    item_d.seq        = seq_d;
    item_d.chunk_idx  = cn;
    item_d.total      = total_w[swcf_pkg::CIDX_W-1:0];
    item_d.cnt        = 16'(cnt);
    item_d.hdr        = (sic == '0);
    item_d.last_frame = last_frame;
    item_d.last_win   = last_win;
  end

  // A zero-length window swallows the sample without any effect.
  assign keep = in_take && !n_zero;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= swcf_pkg::WINDOW_RESET;
      seq_q <= '0;
      siw_q <= '0;
      cn_q  <= '0;
      sic_q <= '0;
    end else if (cfg_valid_i) begin
      // Write the length and abandon any open window.
      win_q <= cfg_data_i;
      siw_q <= '0;
      cn_q  <= '0;
      sic_q <= '0;
    end else if (keep) begin
      seq_q <= seq_d;
      siw_q <= siw_d;
      cn_q  <= cn_d;
      sic_q <= sic_d;
    end
  end

  // --------------------------------------------------------------------------
  // Sample register.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (keep) begin
      item_valid_q <= 1'b1;
    end else if (frame_load) begin
      item_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (keep) begin
      item_q <= item_d;
    end
  end

  // --------------------------------------------------------------------------
  // Scale the three axes and lay out the frame bytes.
  // --------------------------------------------------------------------------
  swcf_scale u_scale_x (.raw_i(item_q.sample.accel_x), .milli_o(milli_x));
  swcf_scale u_scale_y (.raw_i(item_q.sample.accel_y), .milli_o(milli_y));
  swcf_scale u_scale_z (.raw_i(item_q.sample.accel_z), .milli_o(milli_z));

  always_comb begin
    frame_d[0]  = item_q.seq[7:0];
    frame_d[1]  = item_q.seq[15:8];
    frame_d[2]  = item_q.seq[23:16];
    frame_d[3]  = item_q.seq[31:24];
    frame_d[4]  = item_q.chunk_idx;
    frame_d[5]  = item_q.total;
    frame_d[6]  = item_q.cnt[7:0];
    frame_d[7]  = item_q.cnt[15:8];
    frame_d[8]  = milli_x[7:0];
    frame_d[9]  = milli_x[15:8];
    frame_d[10] = milli_y[7:0];
    frame_d[11] = milli_y[15:8];
    frame_d[12] = milli_z[7:0];
    frame_d[13] = milli_z[15:8];
  end

  // --------------------------------------------------------------------------
  // Frame register and byte index. Skip the header when the sample does not
  // open a chunk.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_valid_q <= 1'b0;
      idx_q         <= '0;
    end else if (frame_load) begin
      frame_valid_q <= 1'b1;
      idx_q         <= item_q.hdr ? '0 : PAYLOAD_IDX;
    end else if (frame_done) begin
      frame_valid_q <= 1'b0;
    end else if (adv) begin
      idx_q         <= idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (frame_load) begin
      frame_q    <= frame_d;
      frame_lf_q <= item_q.last_frame;
      frame_lw_q <= item_q.last_win;
    end
  end

  // --------------------------------------------------------------------------
  // Output register: marks ride on the last payload byte only.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q.frame_byte     <= frame_q[idx_q];
      out_q.last_of_frame  <= (idx_q == LAST_IDX) && frame_lf_q;
      out_q.last_of_window <= (idx_q == LAST_IDX) && frame_lw_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

@@ rtl/swcf_scale.sv @@
// ----------------------------------------------------------------------------
// swcf_scale
// Q15.16 g to int16 milli-g: times 1000, round half away from zero, saturate.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module swcf_scale (
  input  logic signed [31:0] raw_i,
  output logic        [15:0] milli_o
);

  logic        neg;
  logic [31:0] mag;
  logic [41:0] prod;
  logic [41:0] rnd;
  logic [25:0] q;

  always_comb begin
    neg  = raw_i[31];
    // Magnitude of the most negative code is 2^31, which still fits.
    mag  = neg ? (~raw_i + 32'd1) : raw_i;
    prod = {10'd0, mag} * 42'd1000;
    rnd  = prod + 42'd32768;
    q    = rnd[41:16];
    if (!neg) begin
      milli_o = (q > 26'd32767) ? 16'h7FFF : q[15:0];
    end else begin
      milli_o = (q > 26'd32768) ? 16'h8000 : (~q[15:0] + 16'd1);
    end
  end

endmodule

@@ rtl/swcf_checker.sv @@
// ----------------------------------------------------------------------------
// swcf_checker
// Port-level checks on the chunk framer, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sample_window_chunk_framer_top_macros.svh"

module swcf_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input swcf_pkg::out_word_t        out_word_o
);

  `SWCF_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o, "stalled word dropped")
  `SWCF_ASSERT(a_out_stable, out_valid_o && out_stall_i |=> $stable(out_word_o), "stalled word moved")
  `SWCF_ASSERT(a_window_ends_frame, out_valid_o && out_word_o.last_of_window |-> out_word_o.last_of_frame, "no frame end")
  `SWCF_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |=> !out_valid_o, "output valid after reset")

endmodule

bind sample_window_chunk_framer_top swcf_checker u_swcf_checker (.*);

@@ verif/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the sample window chunk framer. A table of directed
// samples and window lengths runs first, then random bursts under random
// window lengths. Every accepted sample is framed by a behavioral predictor
// into the bytes it must produce. Each output word is checked in order,
// field by field, with random gaps on the input and random output stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  localparam int     HALF_PERIOD    = 5;
  localparam int     RESET_CYCLES   = 5;
  // Three register stages deep; leave ample room for a dropped sample to clear.
  localparam int     SETTLE_CYCLES  = 20;
  // Random samples on top of the directed ones, about 130 in all.
  localparam int     RANDOM_SAMPLES = 115;
  localparam int     REPORT_LIMIT   = 10;
  localparam int     DRAIN_LIMIT    = 100000;
  localparam longint TIMEOUT_NS     = 64'd5_000_000;
  // Largest window whose chunk count still fits eight bits.
  localparam int     WIN_MAX_FIT    = 8160;

  typedef enum logic {
    ROW_SAMPLE,
    ROW_WINDOW
  } row_kind_e;

  // One directed step: either a sample, or a new window length. Typed rows
  // carry the milli-g values that the payload must hold.
  typedef struct packed {
    row_kind_e                  kind;
    logic [swcf_pkg::WIN_W-1:0] len;
    logic [31:0]                ax;
    logic [31:0]                ay;
    logic [31:0]                az;
    logic                       typed;
    logic [15:0]                mx;
    logic [15:0]                my;
    logic [15:0]                mz;
  } stim_row_t;

  localparam int DIRECTED_ROWS = 22;
  localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
    // Reset window length of 256: zero, full-scale extremes, unit values.
    '{ROW_SAMPLE, '0, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
      1'b1, 16'h0000, 16'h0000, 16'h0000},
    '{ROW_SAMPLE, '0, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff,
      1'b1, 16'h7fff, 16'h8000, 16'h0000},
    '{ROW_SAMPLE, '0, 32'h0001_0000, 32'hffff_0000, 32'h0000_8000,
      1'b1, 16'h03e8, 16'hfc18, 16'h01f4},
    // Rounding ties, half away from zero.
    '{ROW_SAMPLE, '0, 32'h0000_1000, 32'hffff_f000, 32'h0000_3000,
      1'b0, '0, '0, '0},
    // Just inside and just past the saturation limits.
    '{ROW_SAMPLE, '0, 32'd2147418, 32'd2147484, -32'sd2147550,
      1'b0, '0, '0, '0},
    '{ROW_SAMPLE, '0, -32'sd2147516, 32'h0000_0001, 32'h4000_0000,
      1'b0, '0, '0, '0},
    // One-sample windows: every sample opens and closes a window.
    '{ROW_WINDOW, 13'd1, '0, '0, '0, 1'b0, '0, '0, '0},
    '{ROW_SAMPLE, '0, 32'h0001_2345, 32'hfffe_dcba, 32'h0000_0100,
      1'b0, '0, '0, '0},
    '{ROW_SAMPLE, '0, 32'h0020_0000, 32'hffe0_0000, 32'h000a_5a5a,
      1'b0, '0, '0, '0},
    // Zero length drops samples outright.
    '{ROW_WINDOW, 13'd0, '0, '0, '0, 1'b0, '0, '0, '0},
    '{ROW_SAMPLE, '0, 32'h1234_5678, 32'h8765_4321, 32'h0000_0010,
      1'b0, '0, '0, '0},
    '{ROW_SAMPLE, '0, 32'h0000_0000, 32'h7fff_ffff, 32'h8000_0000,
      1'b0, '0, '0, '0},
    // Chunk count of 256 wraps to zero in the header.
    '{ROW_WINDOW, 13'h1fff, '0, '0, '0, 1'b0, '0, '0, '0},
    '{ROW_SAMPLE, '0, 32'h0000_4000, 32'hffff_c000, 32'h0000_0000,
      1'b0, '0, '0, '0},
    '{ROW_SAMPLE, '0, 32'h0003_0000, 32'hfffd_0000, 32'h0000_0800,
      1'b0, '0, '0, '0},
    '{ROW_WINDOW, 13'd8160, '0, '0, '0, 1'b0, '0, '0, '0},
    '{ROW_SAMPLE, '0, 32'h0000_1234, 32'hffff_1234, 32'h0001_8000,
      1'b0, '0, '0, '0},
    // Short windows roll over into a new sequence number.
    '{ROW_WINDOW, 13'd2, '0, '0, '0, 1'b0, '0, '0, '0},
    '{ROW_SAMPLE, '0, 32'h0000_0400, 32'hffff_fc00, 32'h0002_0000,
      1'b0, '0, '0, '0},
    '{ROW_SAMPLE, '0, 32'h0000_0041, 32'hffff_ffbf, 32'h0000_0000,
      1'b0, '0, '0, '0},
    '{ROW_SAMPLE, '0, 32'h0010_0000, 32'hfff0_0000, 32'h0000_ffff,
      1'b0, '0, '0, '0},
    // Set a longer window length; the next length write replaces it before any sample.
    '{ROW_WINDOW, 13'd33, '0, '0, '0, 1'b0, '0, '0, '0}
  };

  // Clock, reset and block ports.
  logic                       clk_i     = 1'b0;
  logic                       rst_ni    = 1'b0;
  logic                       in_valid  = 1'b0;
  logic                       in_stall;
  swcf_pkg::in_word_t         in_word   = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  swcf_pkg::out_word_t        out_word;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [swcf_pkg::WIN_W-1:0] cfg_data  = '0;

  // Handshake flags, sampled at the rising edge and read at the falling edge.
  logic in_taken  = 1'b0;
  logic cfg_taken = 1'b0;

  // Predictor state: window length and frame position counters.
  logic [swcf_pkg::WIN_W-1:0]  window_len    = swcf_pkg::WINDOW_RESET;
  logic [swcf_pkg::SEQ_W-1:0]  window_seq    = '0;
  logic [swcf_pkg::WIN_W-1:0]  pos_in_window = '0;
  logic [swcf_pkg::CIDX_W-1:0] chunk_idx     = '0;
  logic [5:0]                  pos_in_chunk  = '0;

  // Bytes still owed by the block, oldest first.
  swcf_pkg::out_word_t pending_bytes [$];
  int        mismatches = 0;
  // Set for a phase to run with no input gaps and no output stalls.
  bit        calm = 1'b0;
  int        stall_hold = 0;

  always #HALF_PERIOD clk_i = ~clk_i;

  sample_window_chunk_framer_top i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_word_o  (out_word),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  // Q15.16 g to milli-g, rounded half away from zero and clamped to int16.
  function automatic logic [15:0] to_milli_g(input logic [31:0] raw);
    logic [63:0] mag;
    logic [63:0] q;
    mag = raw[31] ? (64'h1_0000_0000 - {32'd0, raw}) : {32'd0, raw};
    q = (mag * 64'd1000 + 64'd32768) >> 16;
    if (!raw[31]) return (q > 64'd32767) ? 16'h7fff : q[15:0];
    if (q > 64'd32768) q = 64'd32768;
    return 16'(17'h10000 - q[16:0]);
  endfunction

  function automatic void queue_byte(input logic [7:0] b, input logic lf,
                                     input logic lw);
    pending_bytes.push_back(swcf_pkg::out_word_t'{frame_byte: b, last_of_frame: lf,
                                                  last_of_window: lw});
  endfunction

  function automatic void clear_position();
    pos_in_window = '0;
    chunk_idx     = '0;
    pos_in_chunk  = '0;
  endfunction

  // Frame one sample: header bytes when it opens a chunk, then x, y, z
  // little-endian, with the marks on the final byte.
  function automatic void frame_sample(input swcf_pkg::in_word_t w, input logic typed,
                                       input logic [15:0] mx, input logic [15:0] my,
                                       input logic [15:0] mz);
    logic [15:0] axis [3];
    logic [15:0] cnt;
    logic [7:0]  total;
    logic        last_win;
    logic        last_frame;
    int          left;
    if (window_len == '0) return;
    if (pos_in_window >= window_len) clear_position();
    if (pos_in_chunk == '0) begin
      left  = int'(window_len) - int'(pos_in_window);
      cnt   = (left < swcf_pkg::CHUNK_SAMPLES) ? 16'(left) : 16'(swcf_pkg::CHUNK_SAMPLES);
      total = 8'((int'(window_len) + swcf_pkg::CHUNK_SAMPLES - 1) / swcf_pkg::CHUNK_SAMPLES);
      if (pos_in_window == '0) begin
        window_seq = window_seq + 1'b1;
        chunk_idx  = '0;
      end
      queue_byte(window_seq[7:0], 1'b0, 1'b0);
      queue_byte(window_seq[15:8], 1'b0, 1'b0);
      queue_byte(window_seq[23:16], 1'b0, 1'b0);
      queue_byte(window_seq[31:24], 1'b0, 1'b0);
      queue_byte(chunk_idx, 1'b0, 1'b0);
      queue_byte(total, 1'b0, 1'b0);
      queue_byte(cnt[7:0], 1'b0, 1'b0);
      queue_byte(cnt[15:8], 1'b0, 1'b0);
    end
    axis[0] = typed ? mx : to_milli_g(w.accel_x);
    axis[1] = typed ? my : to_milli_g(w.accel_y);
    axis[2] = typed ? mz : to_milli_g(w.accel_z);
    last_win   = (int'(pos_in_window) + 1) >= int'(window_len);
    last_frame = last_win || ((int'(pos_in_chunk) + 1) >= swcf_pkg::CHUNK_SAMPLES);
    for (int a = 0; a < 3; a++) begin
      queue_byte(axis[a][7:0], 1'b0, 1'b0);
      queue_byte(axis[a][15:8], (a == 2) && last_frame, (a == 2) && last_win);
    end
    if (last_win) begin
      clear_position();
    end else begin
      pos_in_window = pos_in_window + 1'b1;
      if (last_frame) begin
        pos_in_chunk = '0;
        chunk_idx    = chunk_idx + 1'b1;
      end else begin
        pos_in_chunk = pos_in_chunk + 1'b1;
      end
    end
  endfunction

  // Mostly short waits, now and then a long one.
  function automatic int pick_gap();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 3);
  endfunction

  // Random axis value: mostly in the unsaturated range, with rounding ties,
  // extremes and raw 32-bit patterns mixed in.
  function automatic logic [31:0] pick_axis();
    logic [31:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = 32'($urandom_range(0, 4_400_000)) - 32'd2_200_000;
      4: v = 32'(2 * $urandom_range(0, 250) + 1) * 32'd4096;
      5: begin
        case ($urandom_range(0, 3))
          0: v = 32'h7fff_ffff;
          1: v = 32'h8000_0000;
          2: v = 32'hffff_ffff;
          default: v = 32'h0000_0000;
        endcase
      end
      default: v = $urandom;
    endcase
    if ($urandom_range(0, 1) == 1 && v != 32'h8000_0000) v = -v;
    return v;
  endfunction

  task automatic flag_byte(input string why, input swcf_pkg::out_word_t want,
                           input swcf_pkg::out_word_t got);
    mismatches++;
    if (mismatches <= REPORT_LIMIT)
      $display("%0t: %s: expected byte %02h frame %0b window %0b, got byte %02h frame %0b window %0b",
               $realtime, why, want.frame_byte, want.last_of_frame, want.last_of_window,
               got.frame_byte, got.last_of_frame, got.last_of_window);
  endtask

  // Lower valid and hold until every owed byte has left, then settle.
  task automatic wait_drained(input int settle);
    in_valid <= 1'b0;
    while (pending_bytes.size() != 0) @(negedge clk_i);
    repeat (settle) @(negedge clk_i);
  endtask

  // Write a new window length on the idle block; this also restarts framing.
  task automatic write_window(input logic [swcf_pkg::WIN_W-1:0] len);
    wait_drained(SETTLE_CYCLES);
    cfg_data  <= len;
    cfg_valid <= 1'b1;
    @(negedge clk_i);
    while (!cfg_taken) @(negedge clk_i);
    cfg_valid  <= 1'b0;
    window_len  = len;
    clear_position();
  endtask

  // Present one sample word and hold it until accepted, then maybe idle.
  task automatic send_sample(input swcf_pkg::in_word_t w, input logic typed,
                             input logic [15:0] mx, input logic [15:0] my,
                             input logic [15:0] mz);
    frame_sample(w, typed, mx, my, mz);
    in_word  <= w;
    in_valid <= 1'b1;
    @(negedge clk_i);
    while (!in_taken) @(negedge clk_i);
    if (!calm && $urandom_range(0, 2) == 0) begin
      in_valid <= 1'b0;
      repeat (pick_gap()) @(negedge clk_i);
    end
  endtask

  // Sample both handshakes with the values they had just before the edge.
  always @(posedge clk_i) begin
    in_taken  <= in_valid && !in_stall;
    cfg_taken <= cfg_valid && cfg_ready;
  end

  // Output stall: bursts of random length, none during calm phases.
  always @(negedge clk_i) begin
    if (stall_hold > 0) begin
      stall_hold--;
    end else if (calm || $urandom_range(0, 2) != 0) begin
      out_stall <= 1'b0;
      stall_hold = calm ? 0 : $urandom_range(0, 4);
    end else begin
      out_stall <= 1'b1;
      stall_hold = pick_gap() - 1;
    end
  end

  // Check every accepted output word against the oldest owed byte.
  always @(posedge clk_i) begin
    swcf_pkg::out_word_t want;
    if (rst_ni && out_valid && !out_stall) begin
      if (pending_bytes.size() == 0) begin
        flag_byte("unexpected byte", '0, out_word);
      end else begin
        want = pending_bytes.pop_front();
        if (out_word.frame_byte !== want.frame_byte ||
            out_word.last_of_frame !== want.last_of_frame ||
            out_word.last_of_window !== want.last_of_window)
          flag_byte("byte mismatch", want, out_word);
      end
    end
  end

  // Hard stop in case the block hangs.
  initial begin
    #(TIMEOUT_NS);
    $display("Verification failed");
    $finish;
  end

  initial begin
    int                         counted;
    int                         burst;
    int                         waited;
    logic [swcf_pkg::WIN_W-1:0] len;
    swcf_pkg::in_word_t         w;
    counted = 0;
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed table: length writes drain first, samples go through the predictor.
    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      if (DIRECTED[r].kind == ROW_WINDOW) begin
        write_window(DIRECTED[r].len);
      end else begin
        w.accel_x = DIRECTED[r].ax;
        w.accel_y = DIRECTED[r].ay;
        w.accel_z = DIRECTED[r].az;
        send_sample(w, DIRECTED[r].typed, DIRECTED[r].mx, DIRECTED[r].my, DIRECTED[r].mz);
      end
    end

    // Random phases: pick a length, then a burst of samples that usually
    // spans chunk and window boundaries. Dropped samples do not count.
    while (counted < RANDOM_SAMPLES) begin
      case ($urandom_range(0, 9))
        0: len = '0;
        1: len = swcf_pkg::WIN_W'(1);
        2: len = swcf_pkg::WIN_W'(swcf_pkg::CHUNK_SAMPLES);
        3: len = swcf_pkg::WIN_W'(swcf_pkg::CHUNK_SAMPLES + 1);
        4: len = swcf_pkg::WIN_W'(2 * swcf_pkg::CHUNK_SAMPLES);
        5: len = swcf_pkg::WIN_W'(WIN_MAX_FIT);
        6: len = '1;
        default: len = swcf_pkg::WIN_W'($urandom_range(2, 70));
      endcase
      write_window(len);
      calm  = ($urandom_range(0, 3) == 0);
      burst = (len == '0) ? $urandom_range(2, 4)
                          : $urandom_range(1, (len > 34) ? 70 : 2 * int'(len) + 2);
      // Stop at the sample budget.
      if (len != '0 && burst > RANDOM_SAMPLES - counted) burst = RANDOM_SAMPLES - counted;
      repeat (burst) begin
        w.accel_x = pick_axis();
        w.accel_y = pick_axis();
        w.accel_z = pick_axis();
        send_sample(w, 1'b0, '0, '0, '0);
        if (len != '0) counted++;
        // Occasionally hold off until the block has emptied.
        if ($urandom_range(0, 39) == 0) wait_drained(1);
      end
    end
    calm = 1'b0;

    // Drain with a bound, let the pipeline settle, then count leftovers.
    in_valid <= 1'b0;
    waited = 0;
    while (pending_bytes.size() != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk_i);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (pending_bytes.size() != 0) begin
      $display("%0d expected bytes never arrived", pending_bytes.size());
      mismatches += pending_bytes.size();
    end

    if (mismatches == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
